// ===== rtl/f32exp_pkg.sv =====
// Shared types, constants and helpers for the single-precision exp pipeline.
`timescale 1ns / 1ps

package f32exp_pkg;

    // Register stages inside one fused multiply-add unit
    localparam int FMA_LAT = 5;
    // Fused multiply-add operations on the datapath
    localparam int FMA_CNT = 11;

    localparam logic [31:0] F_MAGIC    = 32'h4B40_0000;
    localparam logic [31:0] F_ZERO_CUT = 32'hC2CF_F1B4;
    localparam logic [31:0] F_INF_CUT  = 32'h42B1_7217;
    localparam logic [31:0] F_LOG2E    = 32'h3FB8_AA3B;
    localparam logic [31:0] F_MLN2_HI  = 32'hBF31_7218;
    localparam logic [31:0] F_MLN2_LO  = 32'h3102_E308;
    localparam logic [31:0] F_C1       = 32'h3F7F_FFFB;
    localparam logic [31:0] F_C2       = 32'h3EFF_FEE3;
    localparam logic [31:0] F_C3       = 32'h3E2A_AD40;
    localparam logic [31:0] F_C4       = 32'h3D2B_9D0D;
    localparam logic [31:0] F_C5       = 32'h3C07_CFCE;
    localparam logic [31:0] F_ONE      = 32'h3F80_0000;
    localparam logic [31:0] F_PINF     = 32'h7F80_0000;
    localparam logic [31:0] F_DEFNAN   = 32'hFFC0_0000;
    localparam logic [31:0] F_QBIT     = 32'h0040_0000;
    localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] EXP_MIN    = 32'hC100_0000;
    localparam logic [31:0] EXP_MAX    = 32'h3F80_0000;

    typedef struct packed {
        logic [31:0] x_bits;
        logic        last_in;
    } in_word_t;

    typedef struct packed {
        logic [31:0] y_bits;
        logic        last_out;
    } out_word_t;

    // Side data that travels next to the arithmetic units
    typedef struct packed {
        logic        last;
        logic [31:0] x;
        logic        spec;
        logic [31:0] spec_val;
        logic [31:0] sn;
        logic [31:0] so;
        logic [31:0] t2;
        logic [31:0] rx;
        logic [31:0] rf;
    } side_t;

    // Index of the highest set bit (0 for a zero word)
    function automatic logic [5:0] msb63(input logic [62:0] v);
        logic [5:0] m;
        m = 6'd0;
        for (int i = 0; i < 63; i++)
        begin
            if (v[i])
            begin
                m = 6'(i);
            end
        end
        return m;
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return a[30:0] > F_PINF[30:0];
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return a[30:0] == F_PINF[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    // Order key for non-NaN binary32 patterns
    function automatic logic [31:0] fkey(input logic [31:0] a);
        return a[31] ? ~a : (a | 32'h8000_0000);
    endfunction

endpackage

// ===== rtl/f32exp_fma.sv =====
// Pipelined binary32 fused multiply-add, round to nearest even, subnormals kept.
`timescale 1ns / 1ps

module f32exp_fma
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    output logic [31:0] y
);

    // ---------------- stage 1: unpack, specials, multiply ----------------
    logic        sp1, sc1;
    logic [23:0] sig_a, sig_b, sig_c;
    logic [11:0] exp_a, exp_b, exp_c;
    logic        spec1;
    logic [31:0] spec_val1;

    logic [47:0] s1_p_reg;
    logic [11:0] s1_ep_reg;
    logic        s1_sp_reg;
    logic [23:0] s1_cs_reg;
    logic [11:0] s1_ec_reg;
    logic        s1_sc_reg;
    logic        s1_czero_reg;
    logic        s1_spec_reg;
    logic [31:0] s1_spec_val_reg;

    always_comb
    begin
        sp1 = a[31] ^ b[31];
        sc1 = c[31];
        sig_a = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
        sig_b = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
        sig_c = (c[30:23] == 8'd0) ? {1'b0, c[22:0]} : {1'b1, c[22:0]};
        exp_a = (a[30:23] == 8'd0) ? -12'sd149 : ($signed({4'b0, a[30:23]}) - 12'sd150);
        exp_b = (b[30:23] == 8'd0) ? -12'sd149 : ($signed({4'b0, b[30:23]}) - 12'sd150);
        exp_c = (c[30:23] == 8'd0) ? -12'sd149 : ($signed({4'b0, c[30:23]}) - 12'sd150);

        // Resolve special operands in priority order
        spec1 = 1'b1;
        spec_val1 = 32'd0;
        if (f32exp_pkg::is_nan(a))
        begin
            spec_val1 = a | f32exp_pkg::F_QBIT;
        end
        else if (f32exp_pkg::is_nan(b))
        begin
            spec_val1 = b | f32exp_pkg::F_QBIT;
        end
        else if (f32exp_pkg::is_nan(c))
        begin
            spec_val1 = c | f32exp_pkg::F_QBIT;
        end
        else if (f32exp_pkg::is_inf(a) || f32exp_pkg::is_inf(b))
        begin
            if (f32exp_pkg::is_zero(a) || f32exp_pkg::is_zero(b))
            begin
                spec_val1 = f32exp_pkg::F_DEFNAN;
            end
            else if (f32exp_pkg::is_inf(c) && (sc1 != sp1))
            begin
                spec_val1 = f32exp_pkg::F_DEFNAN;
            end
            else
            begin
                spec_val1 = {sp1, f32exp_pkg::F_PINF[30:0]};
            end
        end
        else if (f32exp_pkg::is_inf(c))
        begin
            spec_val1 = c;
        end
        else if (f32exp_pkg::is_zero(a) || f32exp_pkg::is_zero(b))
        begin
            spec_val1 = f32exp_pkg::is_zero(c) ? {sp1 & sc1, 31'd0} : c;
        end
        else
        begin
            spec1 = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg        <= sig_a * sig_b;
            s1_ep_reg       <= exp_a + exp_b;
            s1_sp_reg       <= sp1;
            s1_cs_reg       <= sig_c;
            s1_ec_reg       <= exp_c;
            s1_sc_reg       <= sc1;
            s1_czero_reg    <= f32exp_pkg::is_zero(c);
            s1_spec_reg     <= spec1;
            s1_spec_val_reg <= spec_val1;
        end
    end

    // ---------------- stage 2: normalize product and addend ----------------
    logic [5:0]  p_sh, c_sh;
    logic [61:0] s2_p_reg, s2_c_reg;
    logic [11:0] s2_ep_reg, s2_ec_reg;
    logic        s2_sp_reg, s2_sc_reg, s2_czero_reg, s2_spec_reg;
    logic [31:0] s2_spec_val_reg;

    always_comb
    begin
        p_sh = 6'd61 - f32exp_pkg::msb63({15'd0, s1_p_reg});
        c_sh = 6'd61 - f32exp_pkg::msb63({39'd0, s1_cs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_p_reg        <= {14'd0, s1_p_reg} << p_sh;
            s2_ep_reg       <= s1_ep_reg - {6'd0, p_sh};
            s2_c_reg        <= {38'd0, s1_cs_reg} << c_sh;
            s2_ec_reg       <= s1_ec_reg - {6'd0, c_sh};
            s2_sp_reg       <= s1_sp_reg;
            s2_sc_reg       <= s1_sc_reg;
            s2_czero_reg    <= s1_czero_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
        end
    end

    // ---------------- stage 3: align and add ----------------
    logic        p_big;
    logic [61:0] big, lesser, small_al;
    logic [11:0] ebig, d;
    logic        sbig, ssmall;
    logic [62:0] sum;
    logic [62:0] s3_s_reg;
    logic [11:0] s3_e_reg;
    logic        s3_sign_reg, s3_spec_reg;
    logic [31:0] s3_spec_val_reg;

    always_comb
    begin
        p_big = ($signed(s2_ep_reg) > $signed(s2_ec_reg))
             || ((s2_ep_reg == s2_ec_reg) && (s2_p_reg >= s2_c_reg));
        if (p_big)
        begin
            big = s2_p_reg; ebig = s2_ep_reg; sbig = s2_sp_reg;
            lesser = s2_c_reg; ssmall = s2_sc_reg; d = s2_ep_reg - s2_ec_reg;
        end
        else
        begin
            big = s2_c_reg; ebig = s2_ec_reg; sbig = s2_sc_reg;
            lesser = s2_p_reg; ssmall = s2_sp_reg; d = s2_ec_reg - s2_ep_reg;
        end
        // Shift the smaller addend right, folding lost bits into a sticky bit
        if ($signed(d) >= 12'sd63)
        begin
            small_al = {61'd0, |lesser};
        end
        else
        begin
            small_al = (lesser >> d[5:0])
                     | {61'd0, |(lesser & ((62'd1 << d[5:0]) - 62'd1))};
        end
        if (sbig == ssmall)
        begin
            sum = {1'b0, big} + {1'b0, small_al};
        end
        else
        begin
            sum = {1'b0, big} - {1'b0, small_al};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s2_czero_reg)
            begin
                s3_s_reg    <= {1'b0, s2_p_reg};
                s3_e_reg    <= s2_ep_reg;
                s3_sign_reg <= s2_sp_reg;
            end
            else
            begin
                s3_s_reg    <= sum;
                s3_e_reg    <= ebig;
                s3_sign_reg <= sbig;
            end
            // Exact cancellation gives +0
            s3_spec_reg     <= s2_spec_reg || (!s2_czero_reg && (sum == 63'd0));
            s3_spec_val_reg <= s2_spec_reg ? s2_spec_val_reg : 32'd0;
        end
    end

    // ---------------- stage 4: leading one and rounding position ----------------
    logic [5:0]  m4;
    logic [11:0] ex4;
    logic        normal4;
    logic [62:0] s4_s_reg;
    logic [11:0] s4_ex_reg, s4_sh_reg;
    logic        s4_normal_reg, s4_sign_reg, s4_spec_reg;
    logic [31:0] s4_spec_val_reg;

    always_comb
    begin
        m4 = f32exp_pkg::msb63(s3_s_reg);
        ex4 = {6'd0, m4} + s3_e_reg;
        normal4 = $signed(ex4) >= -12'sd126;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_s_reg        <= s3_s_reg;
            s4_ex_reg       <= ex4;
            s4_sh_reg       <= normal4 ? ({6'd0, m4} - 12'd23) : (-12'sd149 - s3_e_reg);
            s4_normal_reg   <= normal4;
            s4_sign_reg     <= s3_sign_reg;
            s4_spec_reg     <= s3_spec_reg;
            s4_spec_val_reg <= s3_spec_val_reg;
        end
    end

    // ---------------- stage 5: shift, round, pack ----------------
    logic [5:0]  rsh;
    logic [62:0] lsh_val, rsh_val;
    logic [24:0] q, qn;
    logic        rbit, sticky;
    logic [11:0] ex5, biased;
    logic [31:0] packed_val;
    logic [31:0] y_reg;

    always_comb
    begin
        rsh = s4_sh_reg[5:0];
        lsh_val = s4_s_reg << (6'd0 - rsh);
        rsh_val = s4_s_reg >> rsh;
        rbit = 1'b0;
        sticky = 1'b0;
        if ($signed(s4_sh_reg) <= 12'sd0)
        begin
            q = lsh_val[24:0];
        end
        else if ($signed(s4_sh_reg) >= 12'sd64)
        begin
            q = 25'd0;
        end
        else
        begin
            q = rsh_val[24:0];
            rbit = s4_s_reg[rsh - 6'd1];
            sticky = |(s4_s_reg & ((63'd1 << (rsh - 6'd1)) - 63'd1));
        end
        if (rbit && (sticky || q[0]))
        begin
            q = q + 25'd1;
        end
        ex5 = s4_ex_reg;
        qn = q;
        if (q[24])
        begin
            qn = q >> 1;
            ex5 = s4_ex_reg + 12'd1;
        end
        biased = ex5 + 12'd127;
        if (s4_normal_reg)
        begin
            if ($signed(biased) >= 12'sd255)
            begin
                packed_val = {s4_sign_reg, f32exp_pkg::F_PINF[30:0]};
            end
            else
            begin
                packed_val = {s4_sign_reg, biased[7:0], qn[22:0]};
            end
        end
        else
        begin
            packed_val = {s4_sign_reg, 7'd0, q[23:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= s4_spec_reg ? s4_spec_val_reg : packed_val;
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/float32_exp_poly5_core.sv =====
// Single-precision exp(x) with range reduction and a degree-5 polynomial, fully pipelined.
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not held;
// eleven five-stage fused multiply-add units in a chain.
// A stall at the output freezes every stage, so no word is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; the datapath is not reset.

module float32_exp_poly5_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  x_valid,
    output logic                  x_ready,
    input  f32exp_pkg::in_word_t  x_word,
    output logic                  y_valid,
    input  logic                  y_ready,
    output f32exp_pkg::out_word_t y_word
);

    localparam int L  = f32exp_pkg::FMA_LAT;
    localparam int NF = f32exp_pkg::FMA_CNT;
    localparam int NS = NF * L;

    logic en;
    logic [31:0] fa [0:NF-1];
    logic [31:0] fb [0:NF-1];
    logic [31:0] fc [0:NF-1];
    logic [31:0] fy [0:NF-1];

    logic                   valid_reg [1:NS];
    f32exp_pkg::side_t      side_reg  [1:NS];
    f32exp_pkg::side_t      side_next [1:NS];
    f32exp_pkg::side_t      side_in;
    logic                   y_valid_reg;
    f32exp_pkg::out_word_t  y_word_reg;

    logic [31:0] t0, eo, en_s, eo_s;

    // Advance the whole pipeline unless the output word is held
    assign en = !(y_valid_reg && !y_ready);
    assign x_ready = en;

    // Catch out-of-range and NaN inputs at entry
    always_comb
    begin
        side_in = '0;
        side_in.last = x_word.last_in;
        side_in.x = x_word.x_bits;
        side_in.spec = 1'b1;
        if (f32exp_pkg::is_nan(x_word.x_bits))
        begin
            side_in.spec_val = x_word.x_bits | f32exp_pkg::F_QBIT;
        end
        else if (f32exp_pkg::fkey(x_word.x_bits) < f32exp_pkg::fkey(f32exp_pkg::F_ZERO_CUT))
        begin
            side_in.spec_val = 32'd0;
        end
        else if (f32exp_pkg::fkey(x_word.x_bits) > f32exp_pkg::fkey(f32exp_pkg::F_INF_CUT))
        begin
            side_in.spec_val = f32exp_pkg::F_PINF;
        end
        else
        begin
            side_in.spec = 1'b0;
        end
    end

    // Split 2^n into the clamped scale and the remainder scale
    always_comb
    begin
        t0 = fy[0];
        eo = t0 << 23;
        en_s = eo;
        if ($signed(en_s) < $signed(f32exp_pkg::EXP_MIN))
        begin
            en_s = f32exp_pkg::EXP_MIN;
        end
        if ($signed(en_s) > $signed(f32exp_pkg::EXP_MAX))
        begin
            en_s = f32exp_pkg::EXP_MAX;
        end
        eo_s = eo - en_s;
    end

    // Shift side data along, dropping in intermediate results at their taps
    always_comb
    begin
        side_next[1] = side_in;
        for (int s = 2; s <= NS; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[L+1].sn   = en_s + f32exp_pkg::F_ONE;
        side_next[L+1].so   = eo_s + f32exp_pkg::F_ONE;
        side_next[2*L+1].t2 = fy[1];
        side_next[4*L+1].rx = fy[3];
        side_next[8*L+1].rf = fy[7];
    end

    // Operand routing for the chain of fused multiply-adds
    always_comb
    begin
        fa[0]  = x_word.x_bits;      fb[0]  = f32exp_pkg::F_LOG2E;
        fc[0]  = f32exp_pkg::F_MAGIC;
        fa[1]  = fy[0];              fb[1]  = f32exp_pkg::F_ONE;
        fc[1]  = f32exp_pkg::F_MAGIC ^ 32'h8000_0000;
        fa[2]  = fy[1];              fb[2]  = f32exp_pkg::F_MLN2_HI;
        fc[2]  = side_reg[2*L].x;
        fa[3]  = side_reg[3*L].t2;   fb[3]  = f32exp_pkg::F_MLN2_LO;
        fc[3]  = fy[2];
        fa[4]  = f32exp_pkg::F_C5;   fb[4]  = fy[3];
        fc[4]  = f32exp_pkg::F_C4;
        fa[5]  = fy[4];              fb[5]  = side_reg[5*L].rx;
        fc[5]  = f32exp_pkg::F_C3;
        fa[6]  = fy[5];              fb[6]  = side_reg[6*L].rx;
        fc[6]  = f32exp_pkg::F_C2;
        fa[7]  = fy[6];              fb[7]  = side_reg[7*L].rx;
        fc[7]  = f32exp_pkg::F_C1;
        fa[8]  = side_reg[8*L].rx;   fb[8]  = side_reg[8*L].so;
        fc[8]  = f32exp_pkg::F_NEG_ZERO;
        fa[9]  = fy[8];              fb[9]  = side_reg[9*L].rf;
        fc[9]  = side_reg[9*L].so;
        fa[10] = side_reg[10*L].sn;  fb[10] = fy[9];
        fc[10] = f32exp_pkg::F_NEG_ZERO;
    end

    for (genvar j = 0; j < NF; j++)
    begin : g_fma
        f32exp_fma u_fma
        (
            .clk (clk),
            .en  (en),
            .a   (fa[j]),
            .b   (fb[j]),
            .c   (fc[j]),
            .y   (fy[j])
        );
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            y_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[1] <= x_valid;
            for (int s = 2; s <= NS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            y_valid_reg <= valid_reg[NS];
        end
    end

    // Hold side data and the output word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 1; s <= NS; s++)
            begin
                side_reg[s] <= side_next[s];
            end
            y_word_reg.y_bits   <= side_reg[NS].spec ? side_reg[NS].spec_val : fy[NF-1];
            y_word_reg.last_out <= side_reg[NS].last;
        end
    end

    assign y_valid = y_valid_reg;
    assign y_word  = y_word_reg;

endmodule

// ===== test/testbench.sv =====
// Testbench for the single-precision exp pipeline: bit-exact prediction with random handshakes.
`timescale 1ns / 1ps

module testbench;

    logic                  clk;
    logic                  rst_n;
    logic                  x_valid;
    logic                  x_ready;
    f32exp_pkg::in_word_t  x_word;
    logic                  y_valid;
    logic                  y_ready;
    f32exp_pkg::out_word_t y_word;

    float32_exp_poly5_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .x_valid (x_valid),
        .x_ready (x_ready),
        .x_word  (x_word),
        .y_valid (y_valid),
        .y_ready (y_ready),
        .y_word  (y_word)
    );

    localparam int CYCLE_LIMIT = 200000;

    f32exp_pkg::in_word_t  pending_x[$];
    f32exp_pkg::out_word_t expected_y[$];
    int        errors = 0;
    int        words_out = 0;
    int        cycles = 0;
    bit        stim_done = 0;
    int        quiet_from = 300;
    int        quiet_to = 700;
    int        sent = 0;

    // Clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Exact binary32 arithmetic on bit patterns
    function automatic int top_bit(input logic [63:0] v);
        int m;
        m = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                m = i;
            end
        end
        return m;
    endfunction

    function automatic logic [63:0] shift_sticky(input logic [63:0] v, input int d);
        logic [63:0] q;
        if (d <= 0)
        begin
            return v;
        end
        if (d >= 63)
        begin
            return (v != 0) ? 64'd1 : 64'd0;
        end
        q = v >> d;
        if ((v & ((64'd1 << d) - 64'd1)) != 0)
        begin
            q[0] = 1'b1;
        end
        return q;
    endfunction

    function automatic logic [63:0] shift_even(input logic [63:0] v, input int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (sh <= 0)
        begin
            return v;
        end
        if (sh > 64)
        begin
            return 64'd0;
        end
        if (sh == 64)
        begin
            return (v > (64'd1 << 63)) ? 64'd1 : 64'd0;
        end
        q = v >> sh;
        rem = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    function automatic logic [31:0] round_pack(input logic sgn, input logic [63:0] s,
                                               input int e);
        int          m;
        int          ex;
        int          sh;
        logic        normal;
        logic [63:0] q;
        m = top_bit(s);
        ex = m + e;
        normal = (ex >= -126);
        sh = normal ? m - 23 : -149 - e;
        q = (sh < 0) ? (s << (-sh)) : shift_even(s, sh);
        if (q >> 24)
        begin
            q = q >> 1;
            ex++;
        end
        if (normal)
        begin
            if (ex + 127 >= 255)
            begin
                return {sgn, f32exp_pkg::F_PINF[30:0]};
            end
            return {sgn, 8'(ex + 127), q[22:0]};
        end
        return {sgn, q[30:0]};
    endfunction

    function automatic void split_f(input logic [31:0] a, output logic [63:0] sig,
                                    output int e);
        if (a[30:23] == 8'd0)
        begin
            sig = {41'd0, a[22:0]};
            e = -149;
        end
        else
        begin
            sig = {40'd0, 1'b1, a[22:0]};
            e = int'(a[30:23]) - 150;
        end
    endfunction

    function automatic logic nan_f(input logic [31:0] a);
        return a[30:0] > f32exp_pkg::F_PINF[30:0];
    endfunction

    function automatic logic inf_f(input logic [31:0] a);
        return a[30:0] == f32exp_pkg::F_PINF[30:0];
    endfunction

    function automatic logic zero_f(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [31:0] fused_mac(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c);
        logic        sp;
        logic        sc;
        logic        sbig;
        logic        ssmall;
        logic [63:0] p;
        logic [63:0] cs;
        logic [63:0] big;
        logic [63:0] lesser;
        logic [63:0] s;
        int          ea;
        int          eb;
        int          ec;
        int          ep;
        int          n;
        int          ebig;
        int          d;
        sp = a[31] ^ b[31];
        sc = c[31];
        if (nan_f(a)) return a | f32exp_pkg::F_QBIT;
        if (nan_f(b)) return b | f32exp_pkg::F_QBIT;
        if (nan_f(c)) return c | f32exp_pkg::F_QBIT;
        if (inf_f(a) || inf_f(b))
        begin
            if (zero_f(a) || zero_f(b)) return f32exp_pkg::F_DEFNAN;
            if (inf_f(c) && sc != sp) return f32exp_pkg::F_DEFNAN;
            return {sp, f32exp_pkg::F_PINF[30:0]};
        end
        if (inf_f(c)) return c;
        if (zero_f(a) || zero_f(b))
        begin
            if (zero_f(c)) return {sp & sc, 31'd0};
            return c;
        end
        split_f(a, p, ea);
        split_f(b, cs, eb);
        p = p * cs;
        ep = ea + eb;
        n = 61 - top_bit(p);
        p = p << n;
        ep -= n;
        if (zero_f(c)) return round_pack(sp, p, ep);
        split_f(c, cs, ec);
        n = 61 - top_bit(cs);
        cs = cs << n;
        ec -= n;
        if (ep > ec || (ep == ec && p >= cs))
        begin
            big = p; ebig = ep; sbig = sp; lesser = cs; ssmall = sc; d = ep - ec;
        end
        else
        begin
            big = cs; ebig = ec; sbig = sc; lesser = p; ssmall = sp; d = ec - ep;
        end
        lesser = shift_sticky(lesser, d);
        s = (sbig == ssmall) ? big + lesser : big - lesser;
        if (s == 0) return 32'd0;
        return round_pack(sbig, s, ebig);
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] a);
        return a[31] ? ~a : (a | 32'h8000_0000);
    endfunction

    // Predict exp(x) through range reduction and the Horner polynomial
    function automatic logic [31:0] exp_of(input logic [31:0] x);
        logic [31:0] t;
        logic [31:0] eo;
        logic [31:0] en;
        logic [31:0] sn;
        logic [31:0] so;
        logic [31:0] r;
        logic [31:0] p;
        if (nan_f(x)) return x | f32exp_pkg::F_QBIT;
        if (order_key(x) < order_key(f32exp_pkg::F_ZERO_CUT)) return 32'd0;
        if (order_key(x) > order_key(f32exp_pkg::F_INF_CUT)) return f32exp_pkg::F_PINF;
        t = fused_mac(x, f32exp_pkg::F_LOG2E, f32exp_pkg::F_MAGIC);
        eo = t << 23;
        en = eo;
        if ((en ^ 32'h8000_0000) < (f32exp_pkg::EXP_MIN ^ 32'h8000_0000))
            en = f32exp_pkg::EXP_MIN;
        if ((en ^ 32'h8000_0000) > (f32exp_pkg::EXP_MAX ^ 32'h8000_0000))
            en = f32exp_pkg::EXP_MAX;
        eo = eo - en;
        sn = en + f32exp_pkg::F_ONE;
        so = eo + f32exp_pkg::F_ONE;
        t = fused_mac(t, f32exp_pkg::F_ONE, f32exp_pkg::F_MAGIC ^ 32'h8000_0000);
        r = fused_mac(t, f32exp_pkg::F_MLN2_HI, x);
        r = fused_mac(t, f32exp_pkg::F_MLN2_LO, r);
        p = fused_mac(f32exp_pkg::F_C5, r, f32exp_pkg::F_C4);
        p = fused_mac(p, r, f32exp_pkg::F_C3);
        p = fused_mac(p, r, f32exp_pkg::F_C2);
        p = fused_mac(p, r, f32exp_pkg::F_C1);
        r = fused_mac(r, so, f32exp_pkg::F_NEG_ZERO);
        return fused_mac(sn, fused_mac(r, p, so), f32exp_pkg::F_NEG_ZERO);
    endfunction

    function automatic logic [31:0] random_x();
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            // in-range value: magnitude up to about 128
            v = {1'($urandom_range(0, 1)), 8'($urandom_range(96, 133)), 23'($urandom)};
        end
        else if (pick < 80)
        begin
            // near the cutoffs
            v = $urandom_range(0, 1)
                ? (f32exp_pkg::F_ZERO_CUT + 32'($urandom_range(0, 8)) - 32'd4)
                : (f32exp_pkg::F_INF_CUT + 32'($urandom_range(0, 8)) - 32'd4);
        end
        else
        begin
            v = $urandom;
        end
        return v;
    endfunction

    // Fill the stimulus queue
    initial
    begin
        logic [31:0]          directed[$];
        f32exp_pkg::in_word_t w;
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                     f32exp_pkg::F_ZERO_CUT, f32exp_pkg::F_ZERO_CUT + 32'd1,
                     f32exp_pkg::F_ZERO_CUT - 32'd1,
                     f32exp_pkg::F_INF_CUT, f32exp_pkg::F_INF_CUT + 32'd1,
                     f32exp_pkg::F_INF_CUT - 32'd1,
                     32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                     32'hFFBF_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                     32'hFF7F_FFFF, 32'hC2AE_0000, 32'hC2B0_0000, 32'h3F31_7218,
                     32'hC2C8_0000, 32'h3400_0000};
        foreach (directed[i])
        begin
            w.x_bits = directed[i];
            w.last_in = 1'(i & 1);
            pending_x.push_back(w);
        end
        for (int i = 0; i < 1300; i++)
        begin
            w.x_bits = random_x();
            w.last_in = 1'($urandom_range(0, 1));
            pending_x.push_back(w);
        end
    end

    // Drive input words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid <= 1'b0;
            x_word <= '0;
        end
        else
        begin
            if (x_valid && x_ready)
            begin
                sent++;
                expected_y.push_back('{y_bits: exp_of(x_word.x_bits),
                                       last_out: x_word.last_in});
            end
            if (!x_valid || x_ready)
            begin
                if (pending_x.size() > 0 &&
                    ((sent >= quiet_from && sent < quiet_to) || $urandom_range(0, 99) >= 15))
                begin
                    x_valid <= 1'b1;
                    x_word <= pending_x.pop_front();
                end
                else
                begin
                    x_valid <= 1'b0;
                    if (pending_x.size() == 0)
                    begin
                        stim_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Check output words and drive back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        f32exp_pkg::out_word_t want;
        if (!rst_n)
        begin
            y_ready <= 1'b0;
        end
        else
        begin
            cycles++;
            if (y_valid && y_ready)
            begin
                words_out++;
                if (expected_y.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, actual %h/%b", $time,
                             y_word.y_bits, y_word.last_out);
                end
                else
                begin
                    want = expected_y.pop_front();
                    if (want.y_bits !== y_word.y_bits)
                    begin
                        errors++;
                        $display("%0t: y_bits expected %h actual %h", $time,
                                 want.y_bits, y_word.y_bits);
                    end
                    if (want.last_out !== y_word.last_out)
                    begin
                        errors++;
                        $display("%0t: last_out expected %b actual %b", $time,
                                 want.last_out, y_word.last_out);
                    end
                end
            end
            y_ready <= (sent >= quiet_from && sent < quiet_to) || $urandom_range(0, 99) >= 15;
        end
    end

    // Reset, wait for drain, report
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && !x_valid && expected_y.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
        end
        else
        begin
            $display("Checked %0d exp results, directed edge cases plus random values,",
                     words_out);
            $display("with random stalls on both sides; %0d mismatches.", errors);
            if (errors == 0 && expected_y.size() == 0)
            begin
                $display("RESULT: OK");
            end
            else
            begin
                $display("RESULT: ERROR");
            end
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/f32exp_pkg.sv
rtl/f32exp_fma.sv
rtl/float32_exp_poly5_core.sv
test/testbench.sv
